// ----- hw/rtl/dpcr_pkg.sv -----
// ----------------------------------------------------------------------------
// dpcr_pkg
// Types and constants shared by the debounced pulse counter reporter.
// ----------------------------------------------------------------------------
package dpcr_pkg;

    localparam int unsigned DEBOUNCE_MS = 50;
    localparam int unsigned MS_PER_S    = 1000;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned LIMIT_W    = 26;   // 65535 s * 1000 fits

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_EXTERNAL_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIN_ACTIVE_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_THRESHOLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL_S     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL_S     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ID         = 3'd6;

    localparam logic [15:0] WORD_DEFAULT    = 16'hFFFF;
    localparam logic [15:0] DFLT_DELTA      = 16'd1;
    localparam logic [15:0] DFLT_MIN_S      = 16'd10;
    localparam logic [15:0] DFLT_MAX_S      = 16'd600;
    localparam logic [7:0]  CHANNEL_ID_MASK = 8'hFF;

    typedef struct packed {
        logic [31:0] time_ms;
        logic        pin_level;
        logic [15:0] external_count;
        logic        link_busy;
    } poll_t;

    typedef struct packed {
        logic        report_valid;
        logic [7:0]  report_channel;
        logic [15:0] report_count;
        logic [15:0] current_count;
    } report_t;

    // Config as used by the datapath: defaults resolved, intervals in ms.
    typedef struct packed {
        logic               enabled;
        logic               use_ext;
        logic               active_high;
        logic               delta_en;
        logic [15:0]        delta_thr;
        logic [LIMIT_W-1:0] min_ms;     // zero means no minimum
        logic               max_en;
        logic [LIMIT_W-1:0] max_ms;
        logic [7:0]         channel_id;
    } cfg_t;

endpackage

// ----- hw/rtl/dpcr_cfg.sv -----
// ----------------------------------------------------------------------------
// dpcr_cfg
// Configuration registers; resolves default words and scales seconds to ms
// at write time so the poll path only compares.
// ----------------------------------------------------------------------------
module dpcr_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dpcr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dpcr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output dpcr_pkg::cfg_t                      cfg
);

    dpcr_pkg::cfg_t cfg_reg;
    logic [15:0]    word_eff_min;
    logic [15:0]    word_eff_max;
    logic [15:0]    word_eff_delta;

    always_comb
    begin
        word_eff_delta = (cfg_data == dpcr_pkg::WORD_DEFAULT) ? dpcr_pkg::DFLT_DELTA : cfg_data;
        word_eff_min   = (cfg_data == dpcr_pkg::WORD_DEFAULT) ? dpcr_pkg::DFLT_MIN_S : cfg_data;
        word_eff_max   = (cfg_data == dpcr_pkg::WORD_DEFAULT) ? dpcr_pkg::DFLT_MAX_S : cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled     <= 1'b1;
            cfg_reg.use_ext     <= 1'b0;
            cfg_reg.active_high <= 1'b0;
            cfg_reg.delta_en    <= 1'b1;
            cfg_reg.delta_thr   <= dpcr_pkg::DFLT_DELTA;
            cfg_reg.min_ms      <= dpcr_pkg::LIMIT_W'(dpcr_pkg::DFLT_MIN_S)
                                   * dpcr_pkg::LIMIT_W'(dpcr_pkg::MS_PER_S);
            cfg_reg.max_en      <= 1'b1;
            cfg_reg.max_ms      <= dpcr_pkg::LIMIT_W'(dpcr_pkg::DFLT_MAX_S)
                                   * dpcr_pkg::LIMIT_W'(dpcr_pkg::MS_PER_S);
            cfg_reg.channel_id  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dpcr_pkg::REG_CHANNEL_ENABLED:    cfg_reg.enabled     <= cfg_data[0];
                dpcr_pkg::REG_USE_EXTERNAL_COUNT: cfg_reg.use_ext     <= cfg_data[0];
                dpcr_pkg::REG_PIN_ACTIVE_HIGH:    cfg_reg.active_high <= cfg_data[0];
                dpcr_pkg::REG_DELTA_THRESHOLD:
                begin
                    cfg_reg.delta_en  <= (word_eff_delta != 16'd0);
                    cfg_reg.delta_thr <= word_eff_delta;
                end
                dpcr_pkg::REG_MIN_INTERVAL_S:
                    cfg_reg.min_ms <= dpcr_pkg::LIMIT_W'(word_eff_min)
                                      * dpcr_pkg::LIMIT_W'(dpcr_pkg::MS_PER_S);
                dpcr_pkg::REG_MAX_INTERVAL_S:
                begin
                    cfg_reg.max_en <= (word_eff_max != 16'd0);
                    cfg_reg.max_ms <= dpcr_pkg::LIMIT_W'(word_eff_max)
                                      * dpcr_pkg::LIMIT_W'(dpcr_pkg::MS_PER_S);
                end
                dpcr_pkg::REG_CHANNEL_ID:
                    cfg_reg.channel_id <= cfg_data[7:0] & dpcr_pkg::CHANNEL_ID_MASK;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/debounced_pulse_counter_reporter_top.sv -----
// Report beats are registered in the output register or skid entry. One poll
// per cycle while poll_stall is low; counter/debounce state updates in the
// accept cycle, and a two-entry output (register plus skid) decouples the stall.
// Poll stall rises only when both output entries are full.
// Reset (rst_n, async low) loads register defaults and clears counts and timers.
// ----------------------------------------------------------------------------
// debounced_pulse_counter_reporter_top
// Debounced pulse counter with threshold and interval driven reports.
// ----------------------------------------------------------------------------
module debounced_pulse_counter_reporter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dpcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dpcr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            poll_valid,
    output logic                            poll_stall,
    input  dpcr_pkg::poll_t                 poll_data,
    output logic                            rpt_valid,
    input  logic                            rpt_stall,
    output dpcr_pkg::report_t               rpt_data
);

    dpcr_pkg::cfg_t    cfg;
    dpcr_pkg::report_t res;
    dpcr_pkg::report_t out_data_reg;
    dpcr_pkg::report_t skid_data_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;

    logic [15:0] pulse_count_reg,    pulse_count_next;
    logic [15:0] reported_count_reg, reported_count_next;
    logic [31:0] report_time_reg,    report_time_next;
    logic [31:0] press_start_reg,    press_start_next;
    logic        edge_armed_reg,     edge_armed_next;

    logic        accept;
    logic        out_take;
    logic [31:0] since;
    logic [31:0] held;
    logic [15:0] diff;
    logic        due;

    dpcr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign accept     = poll_valid && !poll_stall;
    assign out_take   = out_valid_reg && !rpt_stall;
    assign poll_stall = skid_valid_reg;

    always_comb
    begin
        pulse_count_next    = pulse_count_reg;
        reported_count_next = reported_count_reg;
        report_time_next    = report_time_reg;
        press_start_next    = press_start_reg;
        edge_armed_next     = edge_armed_reg;
        res                 = '0;
        held                = poll_data.time_ms - press_start_reg;
        since               = '0;
        diff                = '0;
        due                 = 1'b0;

        if (!cfg.enabled)
        begin
            pulse_count_next    = '0;
            reported_count_next = '0;
        end
        else
        begin
            if (cfg.use_ext)
                pulse_count_next = poll_data.external_count;
            else if (poll_data.pin_level == cfg.active_high)
            begin
                if (press_start_reg == 32'd0)
                begin
                    // zero marks "not pressed", so a press at time zero is kept as 1
                    press_start_next = (poll_data.time_ms == 32'd0) ? 32'd1 : poll_data.time_ms;
                    edge_armed_next  = 1'b1;
                end
                else if (held > 32'(dpcr_pkg::DEBOUNCE_MS) && edge_armed_reg)
                begin
                    edge_armed_next  = 1'b0;
                    pulse_count_next = pulse_count_reg + 16'd1;
                end
            end
            else
            begin
                edge_armed_next  = 1'b1;
                press_start_next = '0;
            end

            since = poll_data.time_ms - report_time_reg;
            diff  = pulse_count_next - reported_count_reg;
            due   = (since >= 32'(cfg.min_ms))
                    && ((cfg.max_en && since >= 32'(cfg.max_ms))
                        || (cfg.delta_en && diff >= cfg.delta_thr));

            if (due)
            begin
                res.report_valid   = 1'b1;
                res.report_channel = cfg.channel_id;
                res.report_count   = pulse_count_next;
                if (!poll_data.link_busy)
                begin
                    reported_count_next = pulse_count_next;
                    report_time_next    = poll_data.time_ms;
                end
            end
            res.current_count = pulse_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_count_reg    <= '0;
            reported_count_reg <= '0;
            report_time_reg    <= '0;
            press_start_reg    <= '0;
            edge_armed_reg     <= 1'b0;
        end
        else if (accept)
        begin
            pulse_count_reg    <= pulse_count_next;
            reported_count_reg <= reported_count_next;
            report_time_reg    <= report_time_next;
            press_start_reg    <= press_start_next;
            edge_armed_reg     <= edge_armed_next;
        end
    end

    // Output register with skid entry; skid full stalls the poll side.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_data_reg <= skid_data_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
                skid_data_reg <= res;
            else
                out_data_reg <= res;
        end
    end

    assign rpt_valid = out_valid_reg;
    assign rpt_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !rpt_stall) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved to output after beat taken");

    a_disable_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg.enabled) |=> (pulse_count_reg == 16'd0 && reported_count_reg == 16'd0))
        else $error("disabled channel did not clear counts");

    a_no_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rpt_valid && !rpt_data.report_valid)
            |-> (rpt_data.report_count == 16'd0 && rpt_data.report_channel == 8'd0))
        else $error("report fields set on a beat without a report");
`endif

endmodule
